/* sv/mhs_pkg.sv */
// Shared types and constants for the min-heap sorter.
// Used by the front end, back end, top level and testbench; depends on nothing.
`default_nettype none

package mhs_pkg;

   localparam int VAL_W = 32;
   // item_count width: holds a fill level up to the largest store depth
   localparam int CNT_W = 7;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value_res;
      logic                    last_res;
      logic                    dropped;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    store;    // write value at slot
      logic [CNT_W-1:0]        slot;     // fill level before this request
      logic                    last;     // start the sort
      logic [CNT_W-1:0]        total;    // fill level after this request
      logic                    dropped;  // overflow seen in this set
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_GRAB,
      ST_SIFT,
      ST_CMP,
      ST_XREAD,
      ST_XEMIT
   } back_state_type;

endpackage

`default_nettype wire

/* sv/mhs_fifo.sv */
// Small register queue with full/empty flags.
// Generic over width; no package dependency.
`default_nettype none

module mhs_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      slots_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in;
   logic [DEPTH_LOG2-1:0] rd_ff, rd_in;
   logic [DEPTH_LOG2:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rdata   = slots_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* sv/mhs_front.sv */
// Front end: accepts requests, tracks fill level and overflow of the set,
// and classifies each request into a command. Uses mhs_pkg.
`default_nettype none

module mhs_front #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   input  wire mhs_pkg::req_type req_data,
   output logic                 req_full,
   output logic                 cmd_push,
   output mhs_pkg::cmd_type     cmd,
   input  wire logic            cmd_full
);

   logic [mhs_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic                      room;
   logic                      accept;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign room     = (count_ff < mhs_pkg::CNT_W'(MAX_ITEMS));
   assign cmd_push = accept;

   always_comb begin
      cmd.value   = req_data.value;
      cmd.store   = room;
      cmd.slot    = count_ff;
      cmd.last    = req_data.last;
      cmd.total   = room ? count_ff + 1'b1 : count_ff;
      cmd.dropped = ovf_ff || !room;

      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_data.last) begin
            // restart the count for the next set
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = cmd.total;
            ovf_in   = cmd.dropped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

/* sv/mhs_back.sv */
// Back end: heap store, heap build and root extraction sequencer.
// Uses mhs_pkg; fed by the command queue, feeds the result queue.
`default_nettype none

module mhs_back #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mhs_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output logic                  out_push,
   output mhs_pkg::rsp_type      out_data,
   input  wire logic             out_full
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = mhs_pkg::CNT_W;
   localparam int VW = mhs_pkg::VAL_W;

   mhs_pkg::back_state_type state_ff, state_in;

   logic                 build_ff, build_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        size_ff, size_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic signed [VW-1:0] cur_ff, cur_in;
   logic                 drop_ff, drop_in;
   logic signed [VW-1:0] rd_a_ff, rd_b_ff;

   logic [VW-1:0]        mem [MAX_ITEMS];
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [VW-1:0]        mem_wd;
   logic                 rd_en;
   logic [AW-1:0]        ra, rb;

   logic [CW-1:0]        km1;
   logic [CW-1:0]        lft, rgt;
   logic                 r_ok;
   logic signed [VW-1:0] best_val;
   logic                 best_child;
   logic [AW-1:0]        best_idx;
   logic                 sift_end;

   assign km1  = k_ff - 1'b1;
   assign lft  = CW'({pos_ff, 1'b1});
   assign rgt  = lft + 1'b1;
   assign r_ok = (rgt < size_ff);

   // strict compares: left child wins ties over the right child
   always_comb begin
      best_val   = cur_ff;
      best_child = 1'b0;
      best_idx   = lft[AW-1:0];
      if (cur_ff > rd_a_ff) begin
         best_val   = rd_a_ff;
         best_child = 1'b1;
      end
      if (r_ok && (best_val > rd_b_ff)) begin
         best_val   = rd_b_ff;
         best_child = 1'b1;
         best_idx   = rgt[AW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      build_in = build_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      size_in  = size_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      drop_in  = drop_ff;
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = pos_ff;
      mem_wd   = cur_ff;
      rd_en    = 1'b0;
      ra       = '0;
      rb       = '0;
      out_push = 1'b0;
      out_data.value_res = rd_a_ff;
      out_data.last_res  = (km1 == '0);
      out_data.dropped   = drop_ff;
      sift_end = 1'b0;

      unique case (state_ff)
         mhs_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.store) begin
                  mem_we = 1'b1;
                  mem_wa = cmd.slot[AW-1:0];
                  mem_wd = cmd.value;
               end
               if (cmd.last) begin
                  n_in    = cmd.total;
                  drop_in = cmd.dropped;
                  if (cmd.total > CW'(1)) begin
                     build_in = 1'b1;
                     k_in     = cmd.total >> 1;
                     state_in = mhs_pkg::ST_LOAD;
                  end else begin
                     build_in = 1'b0;
                     k_in     = cmd.total;
                     state_in = mhs_pkg::ST_XREAD;
                  end
               end
            end
         end
         mhs_pkg::ST_LOAD: begin
            rd_en    = 1'b1;
            ra       = km1[AW-1:0];
            state_in = mhs_pkg::ST_GRAB;
         end
         mhs_pkg::ST_GRAB: begin
            cur_in   = rd_a_ff;
            pos_in   = km1[AW-1:0];
            size_in  = n_ff;
            state_in = mhs_pkg::ST_SIFT;
         end
         mhs_pkg::ST_SIFT: begin
            if (lft < size_ff) begin
               rd_en    = 1'b1;
               ra       = lft[AW-1:0];
               rb       = r_ok ? rgt[AW-1:0] : lft[AW-1:0];
               state_in = mhs_pkg::ST_CMP;
            end else begin
               mem_we   = 1'b1;
               sift_end = 1'b1;
            end
         end
         mhs_pkg::ST_CMP: begin
            mem_we = 1'b1;
            if (best_child) begin
               // move the smaller child up, carry the sifted value down
               mem_wd   = best_val;
               pos_in   = best_idx;
               state_in = mhs_pkg::ST_SIFT;
            end else begin
               sift_end = 1'b1;
            end
         end
         mhs_pkg::ST_XREAD: begin
            rd_en    = 1'b1;
            ra       = '0;
            rb       = km1[AW-1:0];
            state_in = mhs_pkg::ST_XEMIT;
         end
         mhs_pkg::ST_XEMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (km1 == '0) begin
                  state_in = mhs_pkg::ST_IDLE;
               end else begin
                  cur_in   = rd_b_ff;
                  pos_in   = '0;
                  size_in  = km1;
                  state_in = mhs_pkg::ST_SIFT;
               end
            end
         end
         default: begin
            state_in = mhs_pkg::ST_IDLE;
         end
      endcase

      if (sift_end) begin
         if (build_ff && (k_ff == CW'(1))) begin
            build_in = 1'b0;
            k_in     = n_ff;
            state_in = mhs_pkg::ST_XREAD;
         end else if (build_ff) begin
            k_in     = km1;
            state_in = mhs_pkg::ST_LOAD;
         end else begin
            k_in     = km1;
            state_in = mhs_pkg::ST_XREAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhs_pkg::ST_IDLE;
         build_ff <= 1'b0;
         k_ff     <= '0;
         n_ff     <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         build_ff <= build_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_a_ff <= mem[ra];
         rd_b_ff <= mem[rb];
      end
   end

endmodule

`default_nettype wire

/* sv/min_heap_sorter.sv */
// Top level of the min-heap sorter: front end, command queue, back end
// and result queue. Uses mhs_pkg, mhs_front, mhs_fifo and mhs_back.
//
//   channel   direction  handshake              payload
//   req       in         req_push / req_full    mhs_pkg::req_type
//   rsp       out        rsp_pop / rsp_empty    mhs_pkg::rsp_type
//
// A request is registered in the command queue; the back end writes each store
// into the heap store as it pops the command. A sort builds the heap by sifting
// down each parent in turn, then for each result emits the root and sifts the
// last value down from the root; the two-read heap store port sets the pace.
// Reset is synchronous; the heap store is not cleared.
// A full result queue holds the sequencer; the front keeps taking requests
// until the command queue fills.
`default_nettype none

module min_heap_sorter #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire mhs_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output mhs_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty
);

   localparam int CMD_W = $bits(mhs_pkg::cmd_type);
   localparam int RSP_W = $bits(mhs_pkg::rsp_type);

   mhs_pkg::cmd_type cmd_wr, cmd_rd;
   logic [CMD_W-1:0] cmd_rd_bits;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   mhs_pkg::rsp_type out_data;
   logic [RSP_W-1:0] out_rd_bits;
   logic             out_push, out_full;

   mhs_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr),
      .cmd_full (cmd_full)
   );

   mhs_fifo #(.WIDTH(CMD_W), .DEPTH_LOG2(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (CMD_W'(cmd_wr)),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd_bits),
      .empty (cmd_empty)
   );

   assign cmd_rd = mhs_pkg::cmd_type'(cmd_rd_bits);

   mhs_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   mhs_fifo #(.WIDTH(RSP_W), .DEPTH_LOG2(1)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (RSP_W'(out_data)),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rd_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = mhs_pkg::rsp_type'(out_rd_bits);

endmodule

`default_nettype wire

/* dv/tb_min_heap_sorter.sv */
// Self-checking testbench for min_heap_sorter: directed table, then random sets
// under four idling phases, results compared against an in-bench sort.
// Depends on mhs_pkg and the min_heap_sorter RTL.
`default_nettype none

module tb_min_heap_sorter;

   localparam int SLOTS        = 64;
   localparam int RAND_ITEMS   = 246;
   localparam int NUM_ROWS     = 20;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 2000000;

   localparam logic signed [mhs_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [mhs_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef enum int {
      PH_STEADY,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH
   } idle_phase_type;

   typedef struct {
      logic signed [mhs_pkg::VAL_W-1:0] value;
      bit                               last;
      int                               fill;  // random non-last requests sent first
      bit                               typed;
      logic signed [mhs_pkg::VAL_W-1:0] exp_value;
      bit                               exp_last;
      bit                               exp_dropped;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_push;
   mhs_pkg::req_type req_data;
   logic             req_full;
   logic             rsp_pop;
   mhs_pkg::rsp_type rsp_data;
   logic             rsp_empty;

   idle_phase_type phase = PH_STEADY;
   dir_row_type    dir_rows [NUM_ROWS];

   // set being collected, and the sorted run that its last request releases
   logic signed [mhs_pkg::VAL_W-1:0] held_vals[$];
   bit                               held_overflow;
   mhs_pkg::rsp_type                 sorted_run[$];
   mhs_pkg::rsp_type                 due_sorted[$];
   mhs_pkg::rsp_type                 want;
   logic signed [mhs_pkg::VAL_W-1:0] last_drawn = '0;

   int fail_count  = 0;
   int cycle_count = 0;

   min_heap_sorter #(
      .MAX_ITEMS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit roll_idle(input bit sender);
      int pct;
      pct = 0;
      if (phase == PH_BOTH) begin
         pct = 8;
      end else if (sender && phase == PH_SEND_IDLE) begin
         pct = 48;
      end else if (!sender && phase == PH_RECV_STALL) begin
         pct = 48;
      end
      return $urandom_range(0, 99) < pct;
   endfunction

   // mix of wide values, small clustered values, extremes and repeats
   function automatic logic signed [mhs_pkg::VAL_W-1:0] draw_value();
      logic signed [mhs_pkg::VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = $urandom;
         5, 6:          v = $signed($urandom_range(0, 15)) - 8;
         7:             v = VAL_MIN + $urandom_range(0, 3);
         8:             v = VAL_MAX - $urandom_range(0, 3);
         default:       v = last_drawn;
      endcase
      last_drawn = v;
      return v;
   endfunction

   // store the value if room remains; on last, release the ascending run
   task automatic take_value(input mhs_pkg::req_type r);
      int i;
      int j;
      logic signed [mhs_pkg::VAL_W-1:0] key;
      mhs_pkg::rsp_type item;
      if (held_vals.size() < SLOTS) begin
         held_vals.push_back(r.value);
      end else begin
         held_overflow = 1'b1;
      end
      sorted_run.delete();
      if (r.last) begin
         for (i = 1; i < held_vals.size(); i++) begin
            key = held_vals[i];
            j = i - 1;
            while (j >= 0 && held_vals[j] > key) begin
               held_vals[j+1] = held_vals[j];
               j--;
            end
            held_vals[j+1] = key;
         end
         for (i = 0; i < held_vals.size(); i++) begin
            item.value_res = held_vals[i];
            item.last_res  = (i == held_vals.size() - 1);
            item.dropped   = held_overflow;
            sorted_run.push_back(item);
         end
         held_vals.delete();
         held_overflow = 1'b0;
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input mhs_pkg::req_type r, input bit typed,
                               input mhs_pkg::rsp_type typed_rsp);
      while (roll_idle(1'b1)) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      take_value(r);
      if (r.last) begin
         if (typed) begin
            due_sorted.push_back(typed_rsp);
         end else begin
            foreach (sorted_run[k]) due_sorted.push_back(sorted_run[k]);
         end
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !roll_idle(1'b0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (due_sorted.size() == 0) begin
            $error("unexpected result: value_res %0d last_res %0d dropped %0d",
                   rsp_data.value_res, rsp_data.last_res, rsp_data.dropped);
            fail_count++;
         end else begin
            want = due_sorted.pop_front();
            if (rsp_data.value_res !== want.value_res) begin
               $error("value_res: expected %0d, actual %0d", want.value_res,
                      rsp_data.value_res);
               fail_count++;
            end
            if (rsp_data.last_res !== want.last_res) begin
               $error("last_res: expected %0d, actual %0d", want.last_res,
                      rsp_data.last_res);
               fail_count++;
            end
            if (rsp_data.dropped !== want.dropped) begin
               $error("dropped: expected %0d, actual %0d", want.dropped,
                      rsp_data.dropped);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      mhs_pkg::req_type r;
      mhs_pkg::rsp_type typed_rsp;
      int sent;
      int set_size;
      int roll;
      req_push      = 1'b0;
      req_data      = '0;
      rsp_pop       = 1'b0;
      reset         = 1'b1;
      held_overflow = 1'b0;

      // single-value sets echo their value; the set after an overflow starts clean
      dir_rows = '{
         '{VAL_MIN, 1'b1, 0,  1'b1, VAL_MIN, 1'b1, 1'b0},
         '{VAL_MAX, 1'b1, 0,  1'b1, VAL_MAX, 1'b1, 1'b0},
         '{0,       1'b1, 0,  1'b1, 0,       1'b1, 1'b0},
         '{-1,      1'b1, 0,  1'b1, -1,      1'b1, 1'b0},
         '{5,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{-3,      1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{5,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{VAL_MAX, 1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{VAL_MIN, 1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{0,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{-1,      1'b1, 0,  1'b0, 0,       1'b0, 1'b0},
         '{7,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{7,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{7,       1'b1, 0,  1'b0, 0,       1'b0, 1'b0},
         '{3,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{2,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{1,       1'b0, 0,  1'b0, 0,       1'b0, 1'b0},
         '{0,       1'b1, 0,  1'b0, 0,       1'b0, 1'b0},
         '{42,      1'b1, 64, 1'b0, 0,       1'b0, 1'b0},
         '{9,       1'b1, 0,  1'b1, 9,       1'b1, 1'b0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[n]) begin
         repeat (dir_rows[n].fill) begin
            r.value = draw_value();
            r.last  = 1'b0;
            send_request(r, 1'b0, '0);
         end
         r.value             = dir_rows[n].value;
         r.last              = dir_rows[n].last;
         typed_rsp.value_res = dir_rows[n].exp_value;
         typed_rsp.last_res  = dir_rows[n].exp_last;
         typed_rsp.dropped   = dir_rows[n].exp_dropped;
         send_request(r, dir_rows[n].typed, typed_rsp);
      end

      // mostly short sets; a few around capacity, some of them overflowing
      sent = 0;
      while (sent < RAND_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            set_size = $urandom_range(1, 8);
         end else if (roll < 92) begin
            set_size = $urandom_range(9, 24);
         end else begin
            set_size = $urandom_range(62, 68);
         end
         // trim the final set to the item budget
         if (set_size > RAND_ITEMS - sent) begin
            set_size = RAND_ITEMS - sent;
         end
         for (int k = 0; k < set_size; k++) begin
            phase   = idle_phase_type'((sent * 4) / RAND_ITEMS);
            r.value = draw_value();
            r.last  = (k == set_size - 1);
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
      req_push <= 1'b0;

      while (due_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && due_sorted.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
